### hw/rtl/hpmc_pkg.sv
// package: shared types and constants for the half-pel motion compensation core
package hpmc_pkg;

  localparam int PIX_W   = 8;
  localparam int LANES   = 8;
  localparam int ROW_W   = PIX_W * (LANES + 1);
  localparam int CHUNK_W = PIX_W * LANES;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 2'd2;

  typedef struct packed {
    logic avg_mode;
    logic half_x;
    logic half_y;
  } hpmc_mode_t;

endpackage

### hw/rtl/hpmc_lane.sv
// module: one pixel lane, half-pel interpolation and optional averaging
module hpmc_lane (
  input  hpmc_pkg::hpmc_mode_t            mode,
  input  logic [hpmc_pkg::PIX_W-1:0]      cur_a,
  input  logic [hpmc_pkg::PIX_W-1:0]      cur_b,
  input  logic [hpmc_pkg::PIX_W-1:0]      up_a,
  input  logic [hpmc_pkg::PIX_W-1:0]      up_b,
  input  logic [hpmc_pkg::PIX_W-1:0]      pred,
  output logic [hpmc_pkg::PIX_W-1:0]      res
);

  logic [hpmc_pkg::PIX_W:0]   sum_h;
  logic [hpmc_pkg::PIX_W:0]   sum_v;
  logic [hpmc_pkg::PIX_W+1:0] sum_d;
  logic [hpmc_pkg::PIX_W:0]   sum_p;
  logic [hpmc_pkg::PIX_W-1:0] interp;

  always_comb begin
    sum_h = {1'b0, cur_a} + {1'b0, cur_b} + 9'd1;
    sum_v = {1'b0, up_a} + {1'b0, cur_a} + 9'd1;
    sum_d = {2'b00, up_a} + {2'b00, up_b} + {2'b00, cur_a} + {2'b00, cur_b} + 10'd2;
    if (mode.half_x && mode.half_y) begin
      interp = sum_d[hpmc_pkg::PIX_W+1:2];
    end else if (mode.half_x) begin
      interp = sum_h[hpmc_pkg::PIX_W:1];
    end else if (mode.half_y) begin
      interp = sum_v[hpmc_pkg::PIX_W:1];
    end else begin
      interp = cur_a;
    end
    sum_p = {1'b0, interp} + {1'b0, pred} + 9'd1;
    res   = mode.avg_mode ? sum_p[hpmc_pkg::PIX_W:1] : interp;
  end

endmodule

### hw/rtl/hpmc_line_store.sv
// module: previous-row line store, one entry per chunk position
module hpmc_line_store #(
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [hpmc_pkg::ROW_W-1:0]    wdata,
  output logic [hpmc_pkg::ROW_W-1:0]    rdata
);

  logic [hpmc_pkg::ROW_W-1:0] rows [DEPTH];

  // read before write: the current chunk sees the row above
  assign rdata = rows[addr];

  always_ff @(posedge clk) begin
    if (we) begin
      rows[addr] <= wdata;
    end
  end

endmodule

### hw/rtl/halfpel_motion_compensation_core.sv
// module: top level of the half-pel motion compensation core
//
// usage:
//   input stream (s_*): one beat per 8-pixel reference chunk. s_tdata carries
//   the eight reference pixels, the pixel right of the chunk and the eight
//   existing prediction pixels; s_tuser carries chunk position and the
//   first-row flag; s_tlast marks the final row of the block.
//   output stream (m_*): one beat per predicted chunk, m_tuser echoes the
//   chunk position, m_tlast marks the last chunk of the block.
//   config port: cfg_we/cfg_index/cfg_data write avg_mode, half_x, half_y;
//   write only while the core is idle.
// timing:
//   an accepted input beat appears as an output beat in the cycle after; eight
//   pixel lanes work in parallel and the line store is read and written in the
//   same cycle, so one chunk is taken every cycle while s_tready is high.
//   in vertical modes a first-row beat only fills the line store, no output.
// reset: clears the mode registers and the output valid; the line store is
//   not cleared; the user must write rows before they are read (unchecked).
// stall: the output register holds its beat while m_tready is low, and
//   s_tready drops only when that register is full and not being drained.
module halfpel_motion_compensation_core #(
  parameter int CHUNKS_PER_ROW = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [hpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                                cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [63:0] ref_pixels, [71:64] ref_right_pixel, [135:72] pred_pixels
  input  logic [135:0]                        s_tdata,
  // [0] chunk_index, [1] first_row
  input  logic [1:0]                          s_tuser,
  input  logic                                s_tlast,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [63:0] result_pixels
  output logic [hpmc_pkg::CHUNK_W-1:0]        m_tdata,
  // [0] result_chunk
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam int SLOT_W = (CHUNKS_PER_ROW > 1) ? $clog2(CHUNKS_PER_ROW) : 1;

  hpmc_pkg::hpmc_mode_t mode;

  logic                            accept;
  logic                            produce;
  logic                            chunk_index;
  logic                            first_row;
  logic                            eob;
  logic [SLOT_W-1:0]               slot;
  logic [hpmc_pkg::ROW_W-1:0]      cur_row;
  logic [hpmc_pkg::ROW_W-1:0]      up_row;
  logic [hpmc_pkg::CHUNK_W-1:0]    pred_pixels;
  logic [hpmc_pkg::CHUNK_W-1:0]    lane_res;

  logic                            out_valid;
  logic [hpmc_pkg::CHUNK_W-1:0]    out_data;
  logic                            out_chunk;
  logic                            out_last;

  // mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpmc_pkg::REG_AVG_MODE: mode.avg_mode <= cfg_data;
        hpmc_pkg::REG_HALF_X:   mode.half_x   <= cfg_data;
        hpmc_pkg::REG_HALF_Y:   mode.half_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input beat
  assign cur_row     = s_tdata[hpmc_pkg::ROW_W-1:0];
  assign pred_pixels = s_tdata[135:hpmc_pkg::ROW_W];
  assign chunk_index = s_tuser[0];
  assign first_row   = s_tuser[1];
  assign slot        = (CHUNKS_PER_ROW > 1) ? SLOT_W'(chunk_index) : '0;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  // first row in vertical mode only primes the line store
  assign produce  = !(mode.half_y && first_row);
  assign eob      = s_tlast && ((int'(chunk_index) + 1) >= CHUNKS_PER_ROW);

  hpmc_line_store #(
    .DEPTH  (CHUNKS_PER_ROW),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .addr  (slot),
    .wdata (cur_row),
    .rdata (up_row)
  );

  // eight lanes, each sees its pixel and the right neighbour
  for (genvar i = 0; i < hpmc_pkg::LANES; i++) begin : g_lane
    hpmc_lane u_lane (
      .mode  (mode),
      .cur_a (cur_row[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W]),
      .cur_b (cur_row[hpmc_pkg::PIX_W*(i+1) +: hpmc_pkg::PIX_W]),
      .up_a  (up_row[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W]),
      .up_b  (up_row[hpmc_pkg::PIX_W*(i+1) +: hpmc_pkg::PIX_W]),
      .pred  (pred_pixels[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W]),
      .res   (lane_res[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W])
    );
  end

  // merge stage: lanes gathered into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= produce;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data  <= lane_res;
      out_chunk <= chunk_index;
      out_last  <= eob;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_chunk;
  assign m_tlast  = out_last;

endmodule

### hw/rtl/hpmc_checker.sv
// module: port-level checks for the half-pel motion compensation core, with bind
module hpmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed under stall");

  // empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // an output beat that starts after an idle output comes from an accepted input beat
  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("output beat without input beat");

  // a beat that is not a first row always yields a result
  a_non_first_produces: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[1] |=> m_tvalid)
    else $error("missing result for non-first row");

endmodule

bind halfpel_motion_compensation_core hpmc_checker u_hpmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/halfpel_motion_compensation_core_tb.sv
// testbench for the half-pel motion compensation core: directed table plus random rows
module halfpel_motion_compensation_core_tb;

  localparam int CHUNKS_PER_ROW  = 2;
  localparam int NUM_DIR         = 21;
  localparam int NUM_PHASES      = 12;
  localparam int BEATS_PER_PHASE = 50;
  localparam int LONG_HOLD       = 200;   // receiver back-pressure stretch, in cycles
  localparam int SETTLE_CYCLES   = 4;     // the output is registered, leave some margin
  localparam int STUCK_LIMIT     = 2000;  // cycles with no beat on either side

  // one predicted chunk as it leaves the core
  typedef struct packed {
    logic [63:0] pixels;
    logic        chunk;
    logic        eob;
  } chunk_result_t;

  // one row of the directed table; exp_* only used when typed is set
  typedef struct packed {
    hpmc_pkg::hpmc_mode_t mode;
    logic [63:0] ref_pix;
    logic [7:0]  right_pix;
    logic [63:0] pred_pix;
    logic        chunk;
    logic        first;
    logic        last;
    logic        typed;
    logic        has_res;
    logic [63:0] exp_pix;
    logic        exp_eob;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [hpmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                           cfg_data = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [135:0]                   s_tdata = '0;
  logic [1:0]                     s_tuser = '0;
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [hpmc_pkg::CHUNK_W-1:0]   m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;

  // predictor state: mode registers and the previous-row line store
  hpmc_pkg::hpmc_mode_t cur_mode = '0;
  logic [71:0]   line_store [CHUNKS_PER_ROW];
  logic          row_written [CHUNKS_PER_ROW];
  chunk_result_t expected_chunks [$];

  // pacing knobs for the sender and the receiver, and the checker's counters
  logic        src_burst = 1'b0;
  logic        sink_burst = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;

  stim_row_t dir_rows [NUM_DIR];

  always #6 clk = ~clk;

  halfpel_motion_compensation_core #(
    .CHUNKS_PER_ROW(CHUNKS_PER_ROW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // rounded average of two pixels, (a+b+1)>>1
  function automatic logic [7:0] avg_round(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // works out the core's answer for one input beat and updates the line store;
  // returns 0 when the beat only fills the store
  function automatic logic predict_chunk(input logic [63:0] refp, input logic [7:0] right,
                                         input logic [63:0] pred, input logic chunk,
                                         input logic first, input logic last,
                                         output chunk_result_t res);
    logic [71:0] cur_row;
    logic [71:0] up_row;
    logic [9:0]  quad;
    logic [7:0]  pix;
    cur_row = {right, refp};
    up_row = line_store[chunk];
    // every beat lands in the store, whatever the mode
    line_store[chunk] = cur_row;
    row_written[chunk] = 1'b1;
    res = '0;
    if (cur_mode.half_y && first) return 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (cur_mode.half_x && cur_mode.half_y) begin
        // diagonal: exact four-way rounding, not a cascade of two averages
        quad = {2'b0, up_row[8*i +: 8]} + {2'b0, up_row[8*i+8 +: 8]}
             + {2'b0, cur_row[8*i +: 8]} + {2'b0, cur_row[8*i+8 +: 8]} + 10'd2;
        pix = quad[9:2];
      end else if (cur_mode.half_x) begin
        pix = avg_round(cur_row[8*i +: 8], cur_row[8*i+8 +: 8]);
      end else if (cur_mode.half_y) begin
        pix = avg_round(up_row[8*i +: 8], cur_row[8*i +: 8]);
      end else begin
        pix = cur_row[8*i +: 8];
      end
      if (cur_mode.avg_mode) pix = avg_round(pix, pred[8*i +: 8]);
      res.pixels[8*i +: 8] = pix;
    end
    res.chunk = chunk;
    res.eob = last && (int'(chunk) + 1 >= CHUNKS_PER_ROW);
    return 1'b1;
  endfunction

  // pixel words lean toward the all-zero and all-ones corners now and then
  function automatic logic [63:0] rnd_pixels();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rnd_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // offer one beat after a random gap and wait for the core to take it;
  // typed rows override the predicted answer with one read straight off the table
  task automatic send_chunk(input logic [63:0] refp, input logic [7:0] right,
                            input logic [63:0] pred, input logic chunk, input logic first,
                            input logic last, input logic typed, input logic typed_has,
                            input chunk_result_t typed_res);
    int unsigned   gap;
    logic          has_res;
    chunk_result_t res;
    // a vertical read of a never-written store entry is off limits,
    // so such a beat is turned into a first row
    if (cur_mode.half_y && !first && !row_written[chunk]) first = 1'b1;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pred, right, refp};
    s_tuser <= {first, chunk};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has_res = predict_chunk(refp, right, pred, chunk, first, last, res);
    if (typed) begin
      has_res = typed_has;
      res = typed_res;
    end
    if (has_res) expected_chunks.push_back(res);
  endtask

  // stop offering, let every expected beat come back, then let the core go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three mode registers, one per cycle
  task automatic apply_mode(input hpmc_pkg::hpmc_mode_t m);
    cfg_we <= 1'b1;
    cfg_index <= hpmc_pkg::REG_AVG_MODE;
    cfg_data <= m.avg_mode;
    @(posedge clk);
    cfg_index <= hpmc_pkg::REG_HALF_X;
    cfg_data <= m.half_x;
    @(posedge clk);
    cfg_index <= hpmc_pkg::REG_HALF_Y;
    cfg_data <= m.half_y;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  // result checker and stall watchdog, both sampled on the rising edge
  always @(posedge clk) begin : result_check
    chunk_result_t got;
    chunk_result_t want;
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser, m_tlast};
        if (expected_chunks.size() == 0) begin
          note_mismatch("unexpected beat", '0, got.pixels);
        end else begin
          want = expected_chunks.pop_front();
          if (got.pixels !== want.pixels) note_mismatch("result_pixels", want.pixels, got.pixels);
          if (got.chunk !== want.chunk)
            note_mismatch("result_chunk", 64'(want.chunk), 64'(got.chunk));
          if (got.eob !== want.eob)
            note_mismatch("end_of_block", 64'(want.eob), 64'(got.eob));
        end
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, expected_chunks.size());
        $display("halfpel_motion_compensation_core_tb NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stall per beat, one long hold on request
  initial begin : result_sink
    int unsigned pause;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        pause = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        pause = sink_burst ? 0 : $urandom_range(0, 14);
      end
      if (pause != 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned   sent;
    int unsigned   rows;
    chunk_result_t typed_res;
    for (int k = 0; k < CHUNKS_PER_ROW; k++) begin
      line_store[k] = '0;
      row_written[k] = 1'b0;
    end

    // directed rows: mode, ref, right, pred, chunk, first, last, typed, has_res, pix, eob
    dir_rows = '{
      // plain copy, first row has no effect without vertical mode
      '{3'b000, 64'h0, 8'h00, '1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 64'h0, 1'b0},
      '{3'b000, '1, 8'hFF, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '1, 1'b1},
      '{3'b000, 64'h0123_4567_89AB_CDEF, 8'h5A, rnd_pixels(), 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
      // horizontal: the right-hand pixel feeds lane 7
      '{3'b010, 64'h0, 8'hFF, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        64'h8000_0000_0000_0000, 1'b0},
      '{3'b010, '1, 8'h00, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
        64'h80FF_FFFF_FFFF_FFFF, 1'b1},
      '{3'b010, 64'h0100_0100_0100_0100, 8'h01, rnd_pixels(), 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 64'h0, 1'b0},
      // vertical: first rows only fill the line store
      '{3'b001, 64'h0, 8'h00, 64'h0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0},
      '{3'b001, '1, 8'hFF, 64'h0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0},
      '{3'b001, '1, 8'hFF, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        64'h8080_8080_8080_8080, 1'b0},
      '{3'b001, 64'h0, 8'h00, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
        64'h8080_8080_8080_8080, 1'b1},
      // diagonal: a quarter must round down, a cascade of averages would give 1
      '{3'b011, 64'h0001_0001_0001_0001, 8'h01, 64'h0, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 64'h0, 1'b0},
      '{3'b011, 64'h0, 8'h00, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0, 1'b0},
      '{3'b011, '1, 8'hFF, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        64'h8080_8080_8080_8080, 1'b0},
      '{3'b011, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b1, 1'b0, 1'b1,
        1'b0, 1'b0, 64'h0, 1'b0},
      // averaging with the existing prediction
      '{3'b100, '1, 8'h00, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        64'h8080_8080_8080_8080, 1'b0},
      '{3'b100, 64'h0, 8'hFF, '1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
        64'h8080_8080_8080_8080, 1'b1},
      // everything on, then averaging with horizontal only
      '{3'b111, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 64'h0, 1'b0},
      '{3'b111, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 64'h0, 1'b0},
      '{3'b111, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b1, 1'b0, 1'b1,
        1'b0, 1'b0, 64'h0, 1'b0},
      '{3'b110, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 64'h0, 1'b0},
      // last row on the left chunk is not the end of the block
      '{3'b101, rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 64'h0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apply_mode(3'b000);

    // directed part, mode changes only once the core has drained
    for (int k = 0; k < NUM_DIR; k++) begin
      if (dir_rows[k].mode != cur_mode) begin
        settle();
        apply_mode(dir_rows[k].mode);
      end
      typed_res = '{dir_rows[k].exp_pix, dir_rows[k].chunk, dir_rows[k].exp_eob};
      send_chunk(dir_rows[k].ref_pix, dir_rows[k].right_pix, dir_rows[k].pred_pix,
                 dir_rows[k].chunk, dir_rows[k].first, dir_rows[k].last,
                 dir_rows[k].typed, dir_rows[k].has_res, typed_res);
    end

    // random part: every mode once, then random ones; mostly whole blocks of rows
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      apply_mode(p < 8 ? hpmc_pkg::hpmc_mode_t'(p[2:0])
                       : hpmc_pkg::hpmc_mode_t'($urandom_range(0, 7)));
      src_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // back-to-back beats against a long receiver hold fill the core up
        src_burst = 1'b1;
        hold_request = 1'b1;
      end
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: flags in any combination
          send_chunk(rnd_pixels(), rnd_pixel(), rnd_pixels(), 1'($urandom),
                     1'($urandom), 1'($urandom), 1'b0, 1'b0, '0);
          sent++;
        end else begin
          rows = $urandom_range(1, 6);
          for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < CHUNKS_PER_ROW; c++) begin
              send_chunk(rnd_pixels(), rnd_pixel(), rnd_pixels(), c[0],
                         r == 0, r == rows - 1, 1'b0, 1'b0, '0);
              sent++;
            end
          end
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("halfpel_motion_compensation_core_tb OK");
    end else begin
      $display("halfpel_motion_compensation_core_tb NOT OK");
    end
    $finish;
  end

endmodule
